// ===== rtl/core/ttx28_pkg.sv =====
// ----------------------------------------------------------------------------
// Teletext X/28 format 1 decoder package
// Beat types, record kinds and sizing constants shared by the decoder files.
// ----------------------------------------------------------------------------
package ttx28_pkg;

	localparam int COLOUR_ENTRIES = 16;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW        = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_COLOUR  = 2'd1;
	localparam logic [1:0] KIND_TRAILER = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	typedef struct packed {
		logic [7:0] byte_low;
		logic [7:0] byte_mid;
		logic [7:0] byte_high;
		logic       packet_start;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [3:0]  colour_index;
		logic [11:0] colour_value;
		logic [6:0]  default_charset;
		logic [6:0]  second_charset;
		logic [2:0]  panel_flags;
		logic [3:0]  panel_columns;
		logic [4:0]  screen_colour;
		logic [4:0]  row_colour;
		logic        black_substitute;
		logic [2:0]  remap_mode;
		logic        last;
	} out_beat_t;

	typedef struct packed {
		logic        ok;
		logic [17:0] data;
	} ham_result_t;

endpackage

// ===== rtl/core/ttx28_hamming.sv =====
// ----------------------------------------------------------------------------
// Hamming 24/18 triplet decoder
// Checks one triplet, corrects a single error and flags anything worse.
// ----------------------------------------------------------------------------
module ttx28_hamming
	import ttx28_pkg::*;
(
	input  logic [23:0] triplet,
	output ham_result_t result
);

	logic [4:0]  syn;
	logic [4:0]  err;
	logic        par;
	logic [23:0] fixed;

	always_comb begin
		syn = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (triplet[i]) begin
				syn = syn ^ 5'(i + 1);
			end
		end
		par = ^triplet;
		// Each set bit marks a failed parity test A..E.
		err = syn ^ 5'h1f;
		fixed = triplet;
		if (par) begin
			result.ok = (err == 5'd0);
		end else begin
			result.ok = (err <= 5'd23);
			if (err != 5'd0 && err <= 5'd23) begin
				fixed = triplet ^ (24'd1 << (err - 5'd1));
			end
		end
		result.data = {fixed[22:16], fixed[14:8], fixed[6:4], fixed[2]};
	end

endmodule

// ===== rtl/core/teletext_x28_format1_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Teletext X/28 format 1 decoder, top level
// Input beats are registered, and their result beats go to a 4-entry queue.
// Throughput: one triplet per cycle while that queue has room for two beats;
// a triplet yields up to two result beats, one beat leaving per out_ready cycle.
// Reset: arst_n clears the queue and the packet state; the decoder then waits
// for a beat with packet_start set.
// ----------------------------------------------------------------------------
module teletext_x28_format1_decoder_top
	import ttx28_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	// Input stage
	logic     in_valid_s1;
	in_beat_t in_s1;

	// Packet state
	logic        aborted_q;
	logic [3:0]  tc_q;
	logic [4:0]  cc_q;
	logic [4:0]  bc_q;
	logic [25:0] buf_q;
	logic [17:0] first_q;

	// Result queue
	out_beat_t          fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	ham_result_t ham;
	logic        s1_go;
	logic        pop;
	logic        space_ok;
	logic [FIFO_CW-1:0] cnt_after_pop;

	logic        abort_eff;
	logic [3:0]  tc_e;
	logic [4:0]  cc_e;
	logic [4:0]  bc_e;
	logic [25:0] buf_e;

	logic        aborted_n;
	logic [3:0]  tc_n;
	logic [4:0]  cc_n;
	logic [5:0]  bc_w;
	logic [25:0] buf_w;
	logic [17:0] first_n;
	logic [1:0]  rec_n;
	out_beat_t   rec0;
	out_beat_t   rec1;
	out_beat_t   rec_tmp;
	logic [1:0]  push;

	ttx28_hamming u_hamming (
		.triplet ({in_s1.byte_high, in_s1.byte_mid, in_s1.byte_low}),
		.result  (ham)
	);

	assign pop           = out_valid && out_ready;
	assign cnt_after_pop = cnt_q - FIFO_CW'(pop);
	assign space_ok      = cnt_after_pop <= FIFO_CW'(FIFO_DEPTH - 2);
	assign s1_go         = in_valid_s1 && space_ok;
	assign in_ready      = !in_valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// Record building for the triplet held in the input stage.
	always_comb begin
		abort_eff = in_s1.packet_start ? 1'b0 : aborted_q;
		tc_e      = in_s1.packet_start ? 4'd0 : tc_q;
		cc_e      = in_s1.packet_start ? 5'd0 : cc_q;
		bc_e      = in_s1.packet_start ? 5'd0 : bc_q;
		buf_e     = in_s1.packet_start ? 26'd0 : buf_q;

		aborted_n = abort_eff;
		tc_n      = tc_e;
		cc_n      = cc_e;
		bc_w      = {1'b0, bc_e};
		buf_w     = buf_e;
		first_n   = first_q;
		rec_n     = 2'd0;
		rec0      = '0;
		rec1      = '0;
		rec_tmp   = '0;

		if (!abort_eff) begin
			if (!ham.ok) begin
				rec0.record_kind = KIND_ERROR;
				rec0.last        = 1'b1;
				rec_n            = 2'd1;
				aborted_n        = 1'b1;
			end else if (tc_e == 4'd0) begin
				first_n = ham.data;
				tc_n    = 4'd1;
			end else if (tc_e == 4'd1) begin
				rec0.record_kind     = KIND_HEADER;
				rec0.default_charset = first_q[13:7];
				rec0.second_charset  = {ham.data[2:0], first_q[17:14]};
				rec0.panel_flags     = ham.data[5:3];
				rec0.panel_columns   = ham.data[9:6];
				rec_n                = 2'd1;
				buf_w                = 26'(ham.data[17:10]);
				bc_w                 = 6'd8;
				tc_n                 = 4'd2;
			end else begin
				buf_w = buf_e | (26'(ham.data) << bc_e[3:0]);
				bc_w  = {1'b0, bc_e} + 6'd18;
				tc_n  = tc_e + 4'd1;
				// Up to two colour entries leave the bit buffer per triplet.
				for (int k = 0; k < 2; k++) begin
					if (bc_w >= 6'd12 && cc_n < 5'(COLOUR_ENTRIES)) begin
						rec_tmp              = '0;
						rec_tmp.record_kind  = KIND_COLOUR;
						rec_tmp.colour_index = cc_n[3:0];
						rec_tmp.colour_value = buf_w[11:0];
						if (k == 0) begin
							rec0 = rec_tmp;
						end else begin
							rec1 = rec_tmp;
						end
						buf_w = buf_w >> 12;
						bc_w  = bc_w - 6'd12;
						cc_n  = cc_n + 5'd1;
						rec_n = rec_n + 2'd1;
					end
				end
				if (cc_n >= 5'(COLOUR_ENTRIES) && bc_w == 6'd14 && rec_n != 2'd2) begin
					rec_tmp                  = '0;
					rec_tmp.record_kind      = KIND_TRAILER;
					rec_tmp.screen_colour    = buf_w[4:0];
					rec_tmp.row_colour       = buf_w[9:5];
					rec_tmp.black_substitute = buf_w[10];
					rec_tmp.remap_mode       = buf_w[13:11];
					rec_tmp.last             = 1'b1;
					if (rec_n == 2'd0) begin
						rec0 = rec_tmp;
					end else begin
						rec1 = rec_tmp;
					end
					rec_n     = rec_n + 2'd1;
					aborted_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aborted_q <= 1'b1;
			tc_q      <= 4'd0;
			cc_q      <= 5'd0;
			bc_q      <= 5'd0;
			buf_q     <= 26'd0;
			first_q   <= 18'd0;
		end else if (s1_go) begin
			aborted_q <= aborted_n;
			tc_q      <= tc_n;
			cc_q      <= cc_n;
			bc_q      <= bc_w[4:0];
			buf_q     <= buf_w;
			first_q   <= first_n;
		end
	end

	assign push = s1_go ? rec_n : 2'd0;

	always_ff @(posedge clk) begin
		if (push != 2'd0) begin
			fifo_mem[wr_ptr_q] <= rec0;
		end
		if (push == 2'd2) begin
			fifo_mem[wr_ptr_q + FIFO_AW'(1)] <= rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			cnt_q    <= cnt_after_pop + FIFO_CW'(push);
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_data  = fifo_mem[rd_ptr_q];

	// The queue never holds more beats than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overflow");

	// No more colour entries than the map holds are ever counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		cc_q <= 5'(COLOUR_ENTRIES))
		else $error("colour entry count out of range");

	// A bad triplet in an active packet leaves the decoder idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && !abort_eff && !ham.ok |=> aborted_q)
		else $error("decoder still active after an uncorrectable triplet");

	// Trailer and error beats close the packet, other beats do not.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.record_kind == KIND_TRAILER ||
			out_data.record_kind == KIND_ERROR)))
		else $error("last flag does not match the record kind");

endmodule
